@@ hw/rtl/gdpi_pkg.sv @@
// Package for the Gaussian derivative pulse increment block.
// Holds widths, register codes, shared structs and the exp lookup table.
// No dependencies.
`timescale 1ns / 1ps

package gdpi_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int U_SHIFT   = FRAC_BITS + 4;
  localparam int XM_W      = FRAC_BITS + 2;   // |x| below 4.0
  localparam int U_W       = FRAC_BITS + 4;   // x*x below 16.0
  localparam int E_W       = FRAC_BITS + 1;   // exp value up to 1.0
  localparam int XE_W      = FRAC_BITS + 3;
  localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int POS_W     = U_W + IDX_W;
  localparam int PF_W      = 26;
  localparam int PM_W      = 32 + XE_W - FRAC_BITS;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int ADDR_W    = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] AMP_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [MUL_P_W:0] HALF_F = (MUL_P_W + 1)'(64'd1 << (FRAC_BITS - 1));
  localparam logic [MUL_P_W:0] X_LIMIT = (MUL_P_W + 1)'(64'd4 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_FINISH = 3'd1,
    REG_DELAY  = 3'd2,
    REG_FREQ   = 3'd3,
    REG_AMP    = 3'd4,
    REG_STIFF  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]        start_time;
    logic [31:0]        finish_time;
    logic [31:0]        peak_delay;
    logic [23:0]        pulse_frequency;
    logic signed [31:0] amplitude;
    logic [31:0]        stiffness;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic        in_win;
    logic        neg_x;
    logic [31:0] dm;
  } cls_t;

  typedef logic [31:0] exp_rom_t [EXP_TABLE_DEPTH + 1];

  // exp(-r) in Q30, r in Q30 within [0, 1.0]
  function automatic logic [63:0] exp_neg_q30(logic [63:0] r);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * r) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic exp_rom_t build_rom();
    exp_rom_t    rom;
    logic [63:0] einv;
    logic [63:0] u;
    logic [63:0] k;
    logic [63:0] v;
    einv = exp_neg_q30(64'd1 << 30);
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      u = (64'(i) << 34) / 64'(EXP_TABLE_DEPTH);
      k = u >> 30;
      v = exp_neg_q30(u & ((64'd1 << 30) - 64'd1));
      for (int j = 0; j < 16; j++) begin
        if (64'(j) < k) begin
          v = (v * einv + (64'd1 << 29)) >> 30;
        end
      end
      rom[i] = 32'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_rom();

endpackage

@@ hw/rtl/gaussian_derivative_pulse_increment.sv @@
// Gaussian derivative pulse increment: per time sample, stiffness times the change
// of a first-derivative-of-Gaussian pulse. Depends on gdpi_pkg and all gdpi_* modules.
//
// Usage
//   Input queue side: drive time_sample_i and raise push while full is low; the
//   item is taken on that clock edge. Result side: while empty is low the oldest
//   result sits on load_increment_o / in_window_o; raise pop to take it.
//   Every accepted item yields exactly one result, in order.
//   Configuration: APB-style writes at byte address 4*index (start, finish, delay,
//   frequency, amplitude, stiffness); pready is always high. Write only while idle.
// Timing
//   An item in the window passes ten sequencer steps around one shared
//   32x33 multiplier: queue read, pulse frequency, |x|, x*x, table fetch,
//   interpolation, x*e, amplitude, stiffness, hand-off. With |x| >= 4 the
//   x*x to x*e steps are skipped, and an item outside the window goes from
//   queue read straight to hand-off. The sequencer finishes one item before
//   it takes the next; a two-entry queue lets up to two items wait in front
//   of the sequencer.
// Reset
//   Clears the queue, the sequencer, the result valid flag and the stored pulse;
//   registers return to zero, amplitude to 1.0.
// Stall
//   If pop stays low the finished result holds, the sequencer waits, the queue
//   fills and full rises.
`timescale 1ns / 1ps

module gaussian_derivative_pulse_increment
  import gdpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              push,
  output logic              full,
  input  logic [31:0]       time_sample_i,
  // results
  output logic              empty,
  input  logic              pop,
  output logic [47:0]       load_increment_o,
  output logic              in_window_o
);

  cfg_t cfg;
  cls_t cls_in;
  cls_t cls_out;
  logic q_empty;
  logic q_pop;

  gdpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // window test and offset are done at acceptance time
  gdpi_front u_front (
    .cfg_i         (cfg),
    .time_sample_i (time_sample_i),
    .cls_o         (cls_in)
  );

  gdpi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_i      (q_pop),
    .rd_data_o (cls_out),
    .empty_o   (q_empty)
  );

  gdpi_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_empty_i        (q_empty),
    .q_data_i         (cls_out),
    .q_pop_o          (q_pop),
    .pop              (pop),
    .empty            (empty),
    .load_increment_o (load_increment_o),
    .in_window_o      (in_window_o)
  );

endmodule

@@ hw/rtl/gdpi_regs.sv @@
// Configuration registers with an APB-style write/read port.
// Depends on gdpi_pkg.
`timescale 1ns / 1ps

module gdpi_regs
  import gdpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time      <= '0;
      cfg_q.finish_time     <= '0;
      cfg_q.peak_delay      <= '0;
      cfg_q.pulse_frequency <= '0;
      cfg_q.amplitude       <= AMP_ONE;
      cfg_q.stiffness       <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_START:  cfg_q.start_time      <= pwdata;
        REG_FINISH: cfg_q.finish_time     <= pwdata;
        REG_DELAY:  cfg_q.peak_delay      <= pwdata;
        REG_FREQ:   cfg_q.pulse_frequency <= pwdata[23:0];
        REG_AMP:    cfg_q.amplitude       <= pwdata;
        REG_STIFF:  cfg_q.stiffness       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START:  prdata = cfg_q.start_time;
      REG_FINISH: prdata = cfg_q.finish_time;
      REG_DELAY:  prdata = cfg_q.peak_delay;
      REG_FREQ:   prdata = {8'd0, cfg_q.pulse_frequency};
      REG_AMP:    prdata = cfg_q.amplitude;
      REG_STIFF:  prdata = cfg_q.stiffness;
      default:    prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/gdpi_front.sv @@
// Front end: window test and signed offset from the pulse center.
// Depends on gdpi_pkg.
`timescale 1ns / 1ps

module gdpi_front
  import gdpi_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic [31:0] time_sample_i,
  output cls_t        cls_o
);

  logic [31:0] since_start;

  always_comb begin
    since_start  = time_sample_i - cfg_i.start_time;
    cls_o.in_win = (time_sample_i >= cfg_i.start_time) &&
                   (time_sample_i <= cfg_i.finish_time);
    cls_o.neg_x  = since_start < cfg_i.peak_delay;
    cls_o.dm     = cls_o.neg_x ? (cfg_i.peak_delay - since_start)
                               : (since_start - cfg_i.peak_delay);
  end

endmodule

@@ hw/rtl/gdpi_queue.sv @@
// Short queue of classified items between front and back.
// Depends on gdpi_pkg.
`timescale 1ns / 1ps

module gdpi_queue
  import gdpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cls_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cls_t rd_data_o,
  output logic empty_o
);

  cls_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/gdpi_back.sv @@
// Back end: sequencer around one shared multiplier, pulse state and result register.
// Depends on gdpi_pkg.
`timescale 1ns / 1ps

module gdpi_back
  import gdpi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_empty_i,
  input  cls_t         q_data_i,
  output logic         q_pop_o,
  input  logic         pop,
  output logic         empty,
  output logic [47:0]  load_increment_o,
  output logic         in_window_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_PF   = 10'b0000000010,
    ST_XM   = 10'b0000000100,
    ST_U    = 10'b0000001000,
    ST_ROM  = 10'b0000010000,
    ST_INT  = 10'b0000100000,
    ST_XE   = 10'b0001000000,
    ST_PM   = 10'b0010000000,
    ST_OUT  = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  cls_t               cls_q;
  logic [PF_W-1:0]    pf_q;
  logic               big_q;
  logic [XM_W-1:0]    xs_q;
  logic [U_W-1:0]     u_q;
  logic [E_W-1:0]     a_q, step_q, e_q;
  logic [U_SHIFT-1:0] fr_q;
  logic [XE_W-1:0]    xe_q;
  logic [31:0]        prev_q;
  logic [MUL_A_W-1:0] dmo_q;
  logic               nego_q;
  logic [47:0]        res_q;
  logic               res_win_q;
  logic               out_valid_q;
  logic [47:0]        out_inc_q;
  logic               out_win_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W:0]   prod_rf;
  logic [MUL_P_W:0]   prod_sum;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   idx;
  logic [U_SHIFT-1:0] fr;
  logic [E_W-1:0]     rom_a, rom_b;
  logic [31:0]        amag;
  logic               neg_p;
  logic [PM_W-1:0]    pm;
  logic [32:0]        pm_sat;
  logic [32:0]        p_ext;
  logic [32:0]        diff;
  logic [MUL_P_W:0]   cap;
  logic [47:0]        om;
  logic               load_out;

  // one shared multiplier, operands chosen by the sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PF:  begin mul_a = MUL_A_W'(PI_Q30); mul_b = MUL_B_W'(cfg_i.pulse_frequency); end
      ST_XM:  begin mul_a = MUL_A_W'(pf_q);   mul_b = cls_q.dm; end
      ST_U:   begin mul_a = MUL_A_W'(xs_q);   mul_b = MUL_B_W'(xs_q); end
      ST_INT: begin mul_a = MUL_A_W'(step_q); mul_b = MUL_B_W'(fr_q); end
      ST_XE:  begin mul_a = MUL_A_W'(xs_q);   mul_b = MUL_B_W'(e_q); end
      ST_PM:  begin mul_a = MUL_A_W'(xe_q);   mul_b = amag; end
      ST_OUT: begin mul_a = dmo_q;            mul_b = cfg_i.stiffness; end
      default: ;
    endcase
  end

  assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign prod_sum = {1'b0, mul_p} + HALF_F;
  assign prod_rf  = prod_sum >> FRAC_BITS;

  // table position of x*x
  always_comb begin
    pos = POS_W'(u_q) * POS_W'(EXP_TABLE_DEPTH);
    idx = pos[POS_W-1:U_SHIFT];
    fr  = pos[U_SHIFT-1:0];
    if (idx >= IDX_W'(EXP_TABLE_DEPTH)) begin
      idx = IDX_W'(EXP_TABLE_DEPTH - 1);
      fr  = '0;
    end
    rom_a = EXP_ROM[idx][E_W-1:0];
    rom_b = EXP_ROM[idx + 1'b1][E_W-1:0];
  end

  // pulse magnitude, saturation, difference to the stored pulse
  always_comb begin
    amag   = cfg_i.amplitude[31] ? 32'(-cfg_i.amplitude) : cfg_i.amplitude;
    neg_p  = cls_q.neg_x ^ cfg_i.amplitude[31];
    pm     = prod_rf[PM_W-1:0];
    if (neg_p) begin
      pm_sat = (pm > PM_W'(33'h080000000)) ? 33'h080000000 : 33'(pm);
      p_ext  = -pm_sat;
    end else begin
      pm_sat = (pm > PM_W'(33'h07FFFFFFF)) ? 33'h07FFFFFFF : 33'(pm);
      p_ext  = pm_sat;
    end
    diff = p_ext - {prev_q[31], prev_q};
  end

  // final scale by stiffness with 48-bit saturation
  always_comb begin
    cap = nego_q ? (MUL_P_W + 1)'(48'h800000000000) : (MUL_P_W + 1)'(48'h7FFFFFFFFFFF);
    om  = (prod_rf > cap) ? cap[47:0] : prod_rf[47:0];
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || pop);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = q_data_i.in_win ? ST_PF : ST_DONE;
      ST_PF:   state_d = ST_XM;
      ST_XM:   state_d = (prod_rf >= X_LIMIT) ? ST_PM : ST_U;
      ST_U:    state_d = ST_ROM;
      ST_ROM:  state_d = ST_INT;
      ST_INT:  state_d = ST_XE;
      ST_XE:   state_d = ST_PM;
      ST_PM:   state_d = ST_OUT;
      ST_OUT:  state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cls_q     <= q_data_i;
        res_q     <= '0;
        res_win_q <= q_data_i.in_win;
        xe_q      <= '0;
      end
      ST_PF: pf_q <= PF_W'((mul_p + MUL_P_W'(64'd1 << 29)) >> 30);
      ST_XM: begin
        big_q <= prod_rf >= X_LIMIT;
        xs_q  <= prod_rf[XM_W-1:0];
      end
      ST_U: u_q <= prod_rf[U_W-1:0];
      ST_ROM: begin
        a_q    <= rom_a;
        step_q <= (rom_a > rom_b) ? rom_a - rom_b : '0;
        fr_q   <= fr;
      end
      ST_INT: e_q <= a_q - E_W'((mul_p + MUL_P_W'(64'd1 << (U_SHIFT - 1))) >> U_SHIFT);
      ST_XE:  xe_q <= big_q ? '0 : prod_rf[XE_W-1:0];
      ST_PM: begin
        nego_q <= diff[32];
        dmo_q  <= diff[32] ? -diff : diff;
      end
      ST_OUT: res_q <= nego_q ? -om : om;
      default: ;
    endcase
    if (load_out) begin
      out_inc_q <= res_q;
      out_win_q <= res_win_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PM) begin
        prev_q <= p_ext[31:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty            = !out_valid_q;
  assign load_increment_o = out_inc_q;
  assign in_window_o      = out_win_q;

endmodule
